@@ rtl/core/tscu_pkg.sv @@
// Shared types, widths and constants for the Taylor sine, cosine and tangent unit.
// No dependencies; every other file of the unit imports this package.
package tscu_pkg;

    // Field widths of the external channels.
    localparam int ANGLE_W = 32;
    localparam int VALUE_W = 32;
    localparam int THR_W   = 17;

    // Internal fixed-point widths.
    localparam int RED_W  = 56;   // magnitude of the angle in Q8.48
    localparam int XW     = 31;   // reduced angle in Q28, signed
    localparam int TW     = 32;   // one series term in Q28, signed
    localparam int SUMW   = 34;   // series sum in Q28, signed
    localparam int MW     = 35;   // scaled product before the constant division
    localparam int RS     = 45;   // reciprocal scale for the constant division
    localparam int RLW    = 23;   // low slice of the reciprocal
    localparam int RHW    = RS - RLW;
    localparam int NW     = 50;   // tangent dividend
    localparam int QW     = 33;   // tangent quotient bits
    localparam int DW     = 35;   // tangent partial remainder

    // Queue between the front and the back.
    localparam int QPW    = 2;
    localparam int QDEPTH = 1 << QPW;

    // Number of register stages in the front end.
    localparam int FRONT_STAGES = 8;

    localparam logic [RED_W-1:0] PI_Q48     = 56'h3243F6A8885A3;
    localparam logic [RED_W-1:0] TWO_PI_Q48 = 56'h6487ED5110B46;
    localparam logic signed [TW-1:0] ONE_Q28 = 32'sh1000_0000;

    // Function select codes.
    localparam logic [1:0] MODE_SIN = 2'd0;
    localparam logic [1:0] MODE_COS = 2'd1;
    localparam logic [1:0] MODE_TAN = 2'd2;

    // Status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_UNDEF = 2'd1;
    localparam logic [1:0] STAT_SAT   = 2'd2;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

    // One reduced item as it travels from the front through the queue.
    typedef struct packed {
        logic [1:0]           mode;
        logic signed [XW-1:0] x;
    } item_t;

    // Register stages of one series pipeline: the square, then three per term after the first.
    function automatic int series_latency(input int terms);
        return 1 + 3 * (terms - 1);
    endfunction

endpackage

@@ rtl/core/tscu_ifs.sv @@
// Channel interfaces of the Taylor sine, cosine and tangent unit.
// Depends on tscu_pkg for the field widths.
interface tscu_in_if;
    import tscu_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                mode;
    logic signed [ANGLE_W-1:0] angle;
    modport source (output valid, output mode, output angle, input ready);
    modport sink   (input valid, input mode, input angle, output ready);
endinterface

interface tscu_out_if;
    import tscu_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic [1:0]                status;
    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

interface tscu_cfg_if;
    import tscu_pkg::*;
    logic             valid;
    logic             ready;
    logic [THR_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/tscu_front.sv @@
// Front end: accepts angle transactions and reduces the angle modulo 2*pi to Q28.
// Depends on tscu_pkg and tscu_ifs.
module tscu_front (
    input  logic                 clk,
    input  logic                 rst_n,
    tscu_in_if.sink              item,
    output logic                 q_valid,
    input  logic                 q_ready,
    output tscu_pkg::item_t      q_item
);
    import tscu_pkg::*;

    localparam int LAST = FRONT_STAGES - 1;

    logic [FRONT_STAGES-1:0] vld_reg;
    logic                    en;

    logic [1:0]       mode_reg [FRONT_STAGES];
    logic             sgn_reg  [FRONT_STAGES-1];
    logic [RED_W-1:0] a_reg    [6];
    logic [RED_W-1:0] m_reg;
    logic signed [XW-1:0] x_reg;

    logic [ANGLE_W-1:0] angle_abs;
    logic               wrap;
    logic signed [RED_W:0] r_signed;
    logic signed [RED_W:0] r_round;

    assign en         = !vld_reg[LAST] || q_ready;
    assign item.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], item.valid};
        end
    end

    assign angle_abs = item.angle[ANGLE_W-1] ? (~item.angle + 32'd1) : item.angle;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0]    <= {angle_abs, 24'b0};
            sgn_reg[0]  <= item.angle[ANGLE_W-1];
            mode_reg[0] <= item.mode;
        end
    end

    // Restoring steps that remove 16, 8, 4, 2 and 1 times 2*pi.
    for (genvar j = 1; j < 6; j++)
    begin : g_reduce
        localparam logic [RED_W-1:0] STEP_C = TWO_PI_Q48 << (5 - j);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_reg[j]    <= (a_reg[j-1] >= STEP_C) ? (a_reg[j-1] - STEP_C) : a_reg[j-1];
                sgn_reg[j]  <= sgn_reg[j-1];
                mode_reg[j] <= mode_reg[j-1];
            end
        end
    end

    // Fold a remainder beyond pi back by one period, flipping its sign.
    assign wrap = a_reg[5] > PI_Q48;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg       <= wrap ? (TWO_PI_Q48 - a_reg[5]) : a_reg[5];
            sgn_reg[6]  <= sgn_reg[5] ^ wrap;
            mode_reg[6] <= mode_reg[5];
        end
    end

    assign r_signed = sgn_reg[6] ? -$signed({1'b0, m_reg}) : $signed({1'b0, m_reg});
    assign r_round  = r_signed + $signed((RED_W + 1)'(1) << 19);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg          <= r_round[20 +: XW];
            mode_reg[LAST] <= mode_reg[6];
        end
    end

    assign q_valid     = vld_reg[LAST];
    assign q_item.mode = mode_reg[LAST];
    assign q_item.x    = x_reg;

endmodule

@@ rtl/core/tscu_queue.sv @@
// Small FIFO that decouples the reduction front end from the series back end.
// Depends on tscu_pkg for the item type and depth.
module tscu_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tscu_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output tscu_pkg::item_t out_item
);
    import tscu_pkg::*;

    item_t          mem_reg [QDEPTH];
    logic [QPW-1:0] wr_ptr_reg;
    logic [QPW-1:0] rd_ptr_reg;
    logic [QPW:0]   count_reg;
    logic           wr;
    logic           rd;

    assign in_ready  = count_reg != (QPW + 1)'(QDEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign wr        = in_valid && in_ready;
    assign rd        = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ rtl/core/tscu_series.sv @@
// Pipelined Taylor series for sine or cosine in Q28, three stages per term.
// Depends on tscu_pkg for the fixed-point widths.
module tscu_series #(
    parameter int TERMS = 10,
    parameter bit ODD   = 1'b1
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [tscu_pkg::XW-1:0]      x,
    output logic signed [tscu_pkg::SUMW-1:0]    sum
);
    import tscu_pkg::*;

    localparam int XXW = 2 * XW;
    localparam int PW  = TW + 33;
    localparam logic [XXW-1:0] HALF28 = XXW'(1) << 27;

    logic signed [TW-1:0]   term_reg [TERMS];
    logic signed [SUMW-1:0] sum_reg  [TERMS];
    logic [31:0]            x2_reg   [TERMS];

    logic signed [XXW-1:0] xx;
    logic signed [XXW-1:0] xx_round;

    assign xx       = x * x;
    assign xx_round = xx + $signed(HALF28);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg[0]   <= xx_round[28 +: 32];
            term_reg[0] <= ODD ? TW'(x) : ONE_Q28;
            sum_reg[0]  <= ODD ? SUMW'(x) : SUMW'(ONE_Q28);
        end
    end

    for (genvar k = 1; k < TERMS; k++)
    begin : g_term
        // Divisor of this term and its scaled reciprocal, rounded up.
        localparam int DIV = ODD ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
        localparam logic [RS-1:0] RECIP = RS'(((64'd1 << RS) + 64'(DIV) - 64'd1) / 64'(DIV));
        localparam logic [RLW-1:0] RECIP_LO = RECIP[RLW-1:0];
        localparam logic [RHW-1:0] RECIP_HI = RECIP[RS-1:RLW];

        logic signed [PW-1:0]   p;
        logic [PW-1:0]          p_abs;
        logic [MW+RS-1:0]       prod;
        logic [TW-1:0]          q;

        logic [MW-1:0]          m_reg;
        logic                   neg_a_reg;
        logic [31:0]            x2_a_reg;
        logic signed [SUMW-1:0] sum_a_reg;

        logic [MW+RLW-1:0]      pl_reg;
        logic [MW+RHW-1:0]      ph_reg;
        logic                   neg_b_reg;
        logic [31:0]            x2_b_reg;
        logic signed [SUMW-1:0] sum_b_reg;

        assign p     = term_reg[k-1] * $signed({1'b0, x2_reg[k-1]});
        assign p_abs = p[PW-1] ? -p : p;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg     <= p_abs[28 +: MW];
                neg_a_reg <= term_reg[k-1][TW-1];
                x2_a_reg  <= x2_reg[k-1];
                sum_a_reg <= sum_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pl_reg    <= m_reg * RECIP_LO;
                ph_reg    <= m_reg * RECIP_HI;
                neg_b_reg <= neg_a_reg;
                x2_b_reg  <= x2_a_reg;
                sum_b_reg <= sum_a_reg;
            end
        end

        assign prod = {ph_reg, {RLW{1'b0}}} + (MW + RS)'(pl_reg);
        assign q    = prod[RS +: TW];

        // The next term has the opposite sign of the current one.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                term_reg[k] <= neg_b_reg ? $signed(q) : -$signed(q);
                sum_reg[k]  <= sum_b_reg + (neg_b_reg ? SUMW'($signed(q)) : -SUMW'($signed(q)));
                x2_reg[k]   <= x2_b_reg;
            end
        end
    end

    assign sum = sum_reg[TERMS-1];

endmodule

@@ rtl/core/tscu_back.sv @@
// Back end: sine and cosine series, tangent divider and the result register.
// Depends on tscu_pkg, tscu_ifs and tscu_series.
module tscu_back #(
    parameter int TERMS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  tscu_pkg::item_t               q_item,
    input  logic [tscu_pkg::THR_W-1:0]    thr,
    tscu_out_if.source                    result
);
    import tscu_pkg::*;

    localparam int LS   = series_latency(TERMS);
    localparam int NB   = LS + 2 + QW + 1;
    localparam int LAST = NB - 1;
    localparam logic signed [SUMW-1:0] HALF12 = SUMW'(2048);

    logic [NB-1:0] vld_reg;
    logic          en;

    assign en      = !vld_reg[LAST] || result.ready;
    assign q_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NB-2:0], q_valid};
        end
    end

    // Both series run for every item so that tangent has its pair at once.
    logic signed [SUMW-1:0] s;
    logic signed [SUMW-1:0] c;

    tscu_series #(.TERMS(TERMS), .ODD(1'b1)) u_sin (
        .clk (clk),
        .en  (en),
        .x   (q_item.x),
        .sum (s)
    );

    tscu_series #(.TERMS(TERMS), .ODD(1'b0)) u_cos (
        .clk (clk),
        .en  (en),
        .x   (q_item.x),
        .sum (c)
    );

    logic [1:0] mode_reg [LS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode_reg[0] <= q_item.mode;
        end
    end

    for (genvar i = 1; i < LS; i++)
    begin : g_mode
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mode_reg[i] <= mode_reg[i-1];
            end
        end
    end

    // First preparation stage: rounding to Q16.16 and magnitudes.
    logic signed [SUMW-1:0] s_round;
    logic signed [SUMW-1:0] c_round;
    logic signed [SUMW-1:0] c16;

    logic [VALUE_W-1:0] sin16_reg;
    logic [VALUE_W-1:0] cos16_reg;
    logic [SUMW-1:0]    ac16_reg;
    logic [SUMW-1:0]    as_reg;
    logic [SUMW-1:0]    ac_reg;
    logic               czero_reg;
    logic               neg1_reg;
    logic [1:0]         mode1_reg;

    assign s_round = s + HALF12;
    assign c_round = c + HALF12;
    assign c16     = c_round >>> 12;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin16_reg <= VALUE_W'(s_round >>> 12);
            cos16_reg <= VALUE_W'(c16);
            ac16_reg  <= c16[SUMW-1] ? -c16 : c16;
            as_reg    <= s[SUMW-1] ? -s : s;
            ac_reg    <= c[SUMW-1] ? -c : c;
            czero_reg <= c == '0;
            neg1_reg  <= s[SUMW-1] ^ c[SUMW-1];
            mode1_reg <= mode_reg[LS-1];
        end
    end

    // Second preparation stage: threshold test and the rounded dividend.
    logic [NW-1:0]      n2_reg;
    logic [SUMW-1:0]    d2_reg;
    logic               und2_reg;
    logic               neg2_reg;
    logic [1:0]         mode2_reg;
    logic [VALUE_W-1:0] trig2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_reg    <= {as_reg, 16'b0} + NW'(ac_reg >> 1);
            d2_reg    <= ac_reg;
            und2_reg  <= czero_reg || (ac16_reg < SUMW'(thr));
            neg2_reg  <= neg1_reg;
            mode2_reg <= mode1_reg;
            trig2_reg <= (mode1_reg == MODE_SIN) ? sin16_reg : cos16_reg;
        end
    end

    // Restoring divider, one quotient bit per stage.
    logic [NW-1:0]      n_reg    [QW];
    logic [SUMW-1:0]    d_reg    [QW];
    logic [DW-1:0]      rem_reg  [QW];
    logic [QW-1:0]      q_reg    [QW];
    logic               ovf_reg  [QW];
    logic               und_reg  [QW];
    logic               neg_reg  [QW];
    logic [1:0]         dmode_reg[QW];
    logic [VALUE_W-1:0] trig_reg [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        logic [DW-1:0]      rem_in;
        logic [DW-1:0]      shifted;
        logic               ge;
        logic [NW-1:0]      n_in;
        logic [SUMW-1:0]    d_in;
        logic [QW-1:0]      q_in;
        logic               ovf_in;
        logic               und_in;
        logic               neg_in;
        logic [1:0]         mode_in;
        logic [VALUE_W-1:0] trig_in;

        if (i == 0)
        begin : g_first
            assign rem_in  = DW'(n2_reg[NW-1:QW]);
            assign n_in    = n2_reg;
            assign d_in    = d2_reg;
            assign q_in    = '0;
            assign ovf_in  = rem_in >= DW'(d2_reg);
            assign und_in  = und2_reg;
            assign neg_in  = neg2_reg;
            assign mode_in = mode2_reg;
            assign trig_in = trig2_reg;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign n_in    = n_reg[i-1];
            assign d_in    = d_reg[i-1];
            assign q_in    = q_reg[i-1];
            assign ovf_in  = ovf_reg[i-1];
            assign und_in  = und_reg[i-1];
            assign neg_in  = neg_reg[i-1];
            assign mode_in = dmode_reg[i-1];
            assign trig_in = trig_reg[i-1];
        end

        assign shifted = {rem_in[DW-2:0], n_in[QW-1-i]};
        assign ge      = shifted >= DW'(d_in);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]   <= ge ? (shifted - DW'(d_in)) : shifted;
                q_reg[i]     <= {q_in[QW-2:0], ge};
                n_reg[i]     <= n_in;
                d_reg[i]     <= d_in;
                ovf_reg[i]   <= ovf_in;
                und_reg[i]   <= und_in;
                neg_reg[i]   <= neg_in;
                dmode_reg[i] <= mode_in;
                trig_reg[i]  <= trig_in;
            end
        end
    end

    // Result register.
    logic [QW-1:0]      qf;
    logic [VALUE_W-1:0] value_next;
    logic [1:0]         status_next;
    logic [VALUE_W-1:0] value_reg;
    logic [1:0]         status_reg;

    assign qf = q_reg[QW-1];

    always_comb
    begin
        value_next  = '0;
        status_next = STAT_OK;
        case (dmode_reg[QW-1])
            MODE_SIN, MODE_COS:
            begin
                value_next = trig_reg[QW-1];
            end
            MODE_TAN:
            begin
                if (und_reg[QW-1])
                begin
                    status_next = STAT_UNDEF;
                end
                else if (neg_reg[QW-1])
                begin
                    if (ovf_reg[QW-1] || qf > QW'(VALUE_MIN))
                    begin
                        value_next  = VALUE_MIN;
                        status_next = STAT_SAT;
                    end
                    else
                    begin
                        value_next = VALUE_W'(-qf);
                    end
                end
                else if (ovf_reg[QW-1] || qf > QW'(VALUE_MAX))
                begin
                    value_next  = VALUE_MAX;
                    status_next = STAT_SAT;
                end
                else
                begin
                    value_next = qf[VALUE_W-1:0];
                end
            end
            default:
            begin
                value_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign result.valid  = vld_reg[LAST];
    assign result.value  = value_reg;
    assign result.status = status_reg;

endmodule

@@ rtl/core/taylor_sine_cosine_tangent_unit.sv @@
// Top level of the Taylor sine, cosine and tangent unit.
// Depends on tscu_pkg, tscu_ifs, tscu_front, tscu_queue and tscu_back.
//
// When not stalled, the unit takes one transaction per cycle: a signed Q8.24
// angle in radians and a mode (sine, cosine or tangent), and returns exactly
// one Q16.16 result with a status per transaction, in order. The front end
// reduces the angle modulo 2*pi into [-pi, pi] in 8 register stages, a 4-entry
// queue then lets the front and back stall on their own, and the back end sums
// both Taylor series (three stages per term after one squaring stage) and, for
// tangent, divides sine by cosine one quotient bit per stage. With no stall the
// throughput is one transaction per cycle, set by the fully pipelined series
// and divider stages. Tangent reports status 1 and value 0 when the rounded
// cosine magnitude is below the threshold register or the cosine is exactly
// zero, and saturates with status 2 when the quotient leaves the signed 32-bit
// range. Mode 3 returns zero with status 0. The threshold register resets to 1
// and is written through cfg, which is always ready; it should only be written
// while no transaction is in flight.
module taylor_sine_cosine_tangent_unit #(
    parameter int SERIES_TERMS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    tscu_in_if.sink     item,
    tscu_out_if.source  result,
    tscu_cfg_if.sink    cfg
);
    import tscu_pkg::*;

    // Tangent threshold register.
    logic [THR_W-1:0] thr_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_W'(1);
        end
        else if (cfg.valid)
        begin
            thr_reg <= cfg.data;
        end
    end

    // Front end to queue.
    logic  f_valid;
    logic  f_ready;
    item_t f_item;

    // Queue to back end.
    logic  b_valid;
    logic  b_ready;
    item_t b_item;

    tscu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .q_valid (f_valid),
        .q_ready (f_ready),
        .q_item  (f_item)
    );

    tscu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_item  (b_item)
    );

    tscu_back #(.TERMS(SERIES_TERMS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (b_valid),
        .q_ready (b_ready),
        .q_item  (b_item),
        .thr     (thr_reg),
        .result  (result)
    );

endmodule

@@ rtl/core/tscu_checker.sv @@
// Port-level checks for the Taylor sine, cosine and tangent unit, bound to the top.
// Depends on tscu_pkg and on the top level taylor_sine_cosine_tangent_unit.
module tscu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input logic [31:0] result_value,
    input logic [1:0]  result_status
);
    import tscu_pkg::*;

    // A stalled result transaction stays offered.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its payload.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_value) && $stable(result_status))
        else $error("result payload changed while stalled");

    // A saturated tangent sits on one of the two range bounds.
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_status == STAT_SAT |->
            result_value == VALUE_MAX || result_value == VALUE_MIN)
        else $error("saturated result not at a bound");

    // An undefined tangent carries a zero value.
    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_status == STAT_UNDEF |-> result_value == '0)
        else $error("undefined tangent with nonzero value");

endmodule

bind taylor_sine_cosine_tangent_unit tscu_checker u_tscu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .result_value  (result.value),
    .result_status (result.status)
);

@@ test/tb_taylor_sine_cosine_tangent_unit.sv @@
// Self-checking testbench for the Taylor sine, cosine and tangent unit.
// Depends on tscu_pkg, tscu_ifs and the unit's RTL; reads no files.
module tb_taylor_sine_cosine_tangent_unit;
    import tscu_pkg::*;

    localparam int TERMS = 10;
    // Margin waited after the last expected result, for draining.
    localparam int DRAIN_CYCLES = 200;
    localparam logic signed [63:0] PI_FIX  = 64'sh3243F6A8885A3;
    localparam logic signed [63:0] TPI_FIX = 64'sh6487ED5110B46;
    localparam logic signed [63:0] ONE_FIX = 64'sh1000_0000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] angle;
    } stim_t;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } trig_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tscu_in_if  item ();
    tscu_out_if result ();
    tscu_cfg_if cfg ();

    taylor_sine_cosine_tangent_unit #(.SERIES_TERMS(TERMS)) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    always #2 clk = ~clk;

    stim_t       pending_angles[$];
    trig_t       expected_trig[$];
    logic [16:0] threshold = 17'd1;
    int          fail_count = 0;
    bit          sender_hold = 1'b0;
    int          long_stall = 0;
    int          burst_left = 0;
    int          gap_left = 0;

    // Rounds v / 2^sh to nearest with ties toward positive infinity.
    function automatic logic signed [63:0] round_up_half(input logic signed [63:0] v,
                                                         input int sh);
        logic signed [63:0] q;
        q = v + (64'sd1 <<< (sh - 1));
        if (q >= 0)
            return q >>> sh;
        return -((-q + (64'sd1 <<< sh) - 1) >>> sh);
    endfunction

    // Reduces a Q8.24 angle into [-pi, pi] and returns it in Q28.
    function automatic logic signed [63:0] reduce_angle(input logic signed [31:0] a);
        logic signed [63:0] r;
        r = (64'(a) <<< 24) % TPI_FIX;
        if (r > PI_FIX)
            r = r - TPI_FIX;
        if (r < -PI_FIX)
            r = r + TPI_FIX;
        return round_up_half(r, 20);
    endfunction

    // Sums the Taylor series in Q28, sine when odd is set and cosine otherwise.
    function automatic logic signed [63:0] taylor_sum(input logic signed [63:0] x,
                                                      input bit odd);
        logic signed [63:0] x2;
        logic signed [63:0] term;
        logic signed [63:0] sum;
        logic signed [63:0] d;
        x2 = round_up_half(x * x, 28);
        term = odd ? x : ONE_FIX;
        sum = term;
        for (int n = 1; n < TERMS; n++)
        begin
            d = odd ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
            term = -(term * x2) / (d * ONE_FIX);
            sum = sum + term;
        end
        return sum;
    endfunction

    function automatic trig_t predict_trig(input stim_t s);
        trig_t r;
        logic signed [63:0] x, sn, cs, c16, ac16, as, ac, q;
        r.value = '0;
        r.status = STAT_OK;
        x = reduce_angle(s.angle);
        if (s.mode == MODE_SIN)
            r.value = 32'(round_up_half(taylor_sum(x, 1'b1), 12));
        else if (s.mode == MODE_COS)
            r.value = 32'(round_up_half(taylor_sum(x, 1'b0), 12));
        else if (s.mode == MODE_TAN)
        begin
            sn = taylor_sum(x, 1'b1);
            cs = taylor_sum(x, 1'b0);
            c16 = round_up_half(cs, 12);
            ac16 = c16 < 0 ? -c16 : c16;
            if (cs == 0 || ac16 < 64'(threshold))
                r.status = STAT_UNDEF;
            else
            begin
                as = sn < 0 ? -sn : sn;
                ac = cs < 0 ? -cs : cs;
                q = (as * 65536 + ac / 2) / ac;
                if ((sn < 0) != (cs < 0))
                begin
                    q = -q;
                    if (q < -(64'sd1 <<< 31))
                    begin
                        q = -(64'sd1 <<< 31);
                        r.status = STAT_SAT;
                    end
                end
                else if (q > ((64'sd1 <<< 31) - 1))
                begin
                    q = (64'sd1 <<< 31) - 1;
                    r.status = STAT_SAT;
                end
                r.value = 32'(q);
            end
        end
        return r;
    endfunction

    // The driver offers items in bursts of random length separated by random gaps.
    // A new item is presented only after the previous transaction completed, so
    // valid never drops between back-to-back items.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item.valid <= 1'b0;
            item.mode  <= '0;
            item.angle <= '0;
        end
        else
        begin
            automatic bit can_send;
            if (item.valid && item.ready)
                expected_trig.push_back(predict_trig('{item.mode, item.angle}));
            if (!item.valid || item.ready)
            begin
                can_send = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (burst_left > 0)
                begin
                    burst_left--;
                    can_send = 1'b1;
                end
                else if ($urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 8);
                else
                begin
                    burst_left = $urandom_range(0, 30);
                    can_send = 1'b1;
                end
                if (can_send && !sender_hold && pending_angles.size() > 0)
                begin
                    automatic stim_t s = pending_angles.pop_front();
                    item.valid <= 1'b1;
                    item.mode  <= s.mode;
                    item.angle <= s.angle;
                end
                else
                    item.valid <= 1'b0;
            end
        end
    end

    // The receiver stalls on its own pattern, plus a long hold-off when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            if (long_stall > 0)
            begin
                long_stall--;
                result.ready <= 1'b0;
            end
            else
                result.ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0);
        end
    end

    // The monitor compares every result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_trig.size() == 0)
            begin
                $error("unexpected result transaction: value %h status %0d",
                       result.value, result.status);
                fail_count++;
            end
            else
            begin
                automatic trig_t e = expected_trig.pop_front();
                if (result.value !== e.value)
                begin
                    $error("value mismatch: expected %h, actual %h", e.value, result.value);
                    fail_count++;
                end
                if (result.status !== e.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           e.status, result.status);
                    fail_count++;
                end
            end
        end
    end

    task automatic wait_until_drained();
        while (pending_angles.size() > 0 || item.valid || expected_trig.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes the threshold register; only called with the unit idle.
    task automatic write_threshold(input logic [16:0] thr);
        cfg.valid <= 1'b1;
        cfg.data  <= thr;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        threshold = thr;
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_angle();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h0C90_FDAA)) * ($urandom_range(0, 1) ? 1 : -1));
            // Near odd multiples of pi/2, where cosine is small.
            2: return 32'(signed'(32'h0192_1FB5) * (2 * $signed($urandom_range(0, 40)) - 41)
                          + $signed($urandom_range(0, 64)) - 32);
            3: return 32'($signed($urandom_range(0, 4096)) - 2048);
            default: return $urandom() & 32'h07FF_FFFF;
        endcase
    endfunction

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            pending_angles.push_back('{2'($urandom_range(0, 3)), random_angle()});
    endtask

    initial
    begin
        logic [16:0] thr_list[4];
        logic [31:0] edge_angles[10];
        cfg.valid = 1'b0;
        cfg.data  = '0;
        thr_list = '{17'd0, 17'd65536, 17'd1, 17'd300};
        edge_angles = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1,
                        32'h0324_3F6A, 32'hFCDB_C096, 32'h0192_1FB5, 32'hFE6D_E04B,
                        32'h0648_7ED5};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items: angle extremes, multiples of pi/2, each mode incl. unused.
        foreach (edge_angles[i])
            pending_angles.push_back('{MODE_TAN, edge_angles[i]});
        for (int m = 0; m < 4; m++)
        begin
            pending_angles.push_back('{2'(m), 32'h8000_0000});
            pending_angles.push_back('{2'(m), 32'h7FFF_FFFF});
            pending_angles.push_back('{2'(m), 32'h0192_1FB5});
        end
        wait_until_drained();

        // Each threshold setting gets a random phase; the first one also sees a
        // long receiver hold-off so the unit fills up and stalls its input.
        foreach (thr_list[t])
        begin
            write_threshold(thr_list[t]);
            queue_random(480);
            if (t == 0)
            begin
                repeat (50) @(posedge clk);
                long_stall = 300;
            end
            if (t == 2)
            begin
                // The sender pauses until every expected result has come.
                while (pending_angles.size() > 240)
                    @(posedge clk);
                sender_hold = 1'b1;
                while (item.valid || expected_trig.size() > 0)
                    @(posedge clk);
                sender_hold = 1'b0;
            end
            wait_until_drained();
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Worst case is about 2000 items plus drains.
    initial
    begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
